/* hdl/fifo_queue_with_min_max_search_core_defines.svh */
// ----------------------------------------------------------------------------
// FIFO queue with min/max search: assertion macros
// Shared macros for the concurrent checks of the queue core.
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_MIN_MAX_SEARCH_CORE_DEFINES_SVH
`define FIFO_QUEUE_WITH_MIN_MAX_SEARCH_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FQMM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FQMM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/fqmm_pkg.sv */
// ----------------------------------------------------------------------------
// FIFO queue with min/max search: package
// Beat types, command and status codes and the cell control group.
// ----------------------------------------------------------------------------
package fqmm_pkg;

   localparam logic [2:0] OP_PUSH  = 3'd0;
   localparam logic [2:0] OP_POP   = 3'd1;
   localparam logic [2:0] OP_MAX   = 3'd2;
   localparam logic [2:0] OP_MIN   = 3'd3;
   localparam logic [2:0] OP_FIND  = 3'd4;
   localparam logic [2:0] OP_CLEAR = 3'd5;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] operand_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] result_value;
      logic [4:0]         position;
      logic [4:0]         occupancy;
      logic               last;
   } rsp_type;

   // Shift moves every entry one place toward the old end; rotate moves the
   // ring one place toward the head cell.
   typedef struct packed {
      logic shift;
      logic rotate;
   } cell_ctl_type;

endpackage

/* hdl/fifo_queue_with_min_max_search_core.sv */
// ----------------------------------------------------------------------------
// FIFO queue with min/max search: top level
// Bounded queue of signed 32-bit words with push, pop, max, min, find and clear commands.
// ----------------------------------------------------------------------------
// The queue is a ring of DEPTH cells, cell 0 holding the newest entry. A push
// shifts every cell one place toward the old end, and push,
// clear, a refused push, a command on an empty queue and an unused opcode
// (which is dropped without a result) all finish in the cycle they are taken,
// so such commands can follow each other on every clock while the result
// channel keeps up. If the output register still holds a beat that has not
// been taken, the new beat waits in the pending register and the input stalls
// until the output register is free again.
// Pop, max, min and find walk the ring: it rotates one place per cycle so that
// each entry passes the comparator on the head cell, and after DEPTH steps the
// contents are back where they started. A find pauses the rotation while a
// second hit waits for the output register. A walking command keeps the input
// stalled through the DEPTH rotation steps and the hand-off of the final beat
// from the pending register, and longer while the result channel stalls.
// Find returns one beat per matching position, newest first, with
// last set on the final beat; a search for a value that is absent gives one
// not-found beat. A result beat sits in an output register, so a new command
// is taken while the previous result still waits; a further pending-beat
// register holds a result whose output slot is not yet free. Entries beyond
// the fill count are never reported. The position and occupancy fields carry
// the low five bits of the internal counts.
// ----------------------------------------------------------------------------
module fifo_queue_with_min_max_search_core
   import fqmm_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int KW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [KW-1:0] LastStep = KW'(DEPTH - 1);
   localparam logic [CW-1:0] FullCount = CW'(DEPTH);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_SCAN  = 3'b010,
      S_FLUSH = 3'b100
   } state_type;

   // Low five bits of an internal count, as the beat fields carry them.
   function automatic logic [4:0] to_field(input logic [CW-1:0] x);
      logic [31:0] wide;
      wide = 32'(x);
      return wide[4:0];
   endfunction

   state_type          state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff;
   logic [KW-1:0]      step_ff, step_in;
   logic signed [31:0] acc_ff, acc_in;
   logic               hit_ff, hit_in;
   logic [CW-1:0]      hitpos_ff, hitpos_in;
   req_type            op_ff, op_in;
   rsp_type            pend_ff, pend_in;

   logic               accept;
   logic               out_free;
   logic               out_load;
   rsp_type            out_data;
   rsp_type            imm;
   logic               imm_valid;
   cell_ctl_type       ctl;
   logic signed [31:0] cell_val [DEPTH];
   logic signed [31:0] head;
   logic               in_range;
   logic [CW-1:0]      cur_pos;
   logic               match;
   logic               block;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign head      = cell_val[0];

   // Ring of cells. On a push cell 0 takes the operand; while rotating, the
   // last cell takes the head so that nothing is lost.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [31:0] lo_data;
      if (i == 0) begin : g_first
         assign lo_data = req_data.operand_value;
      end else begin : g_rest
         assign lo_data = cell_val[i-1];
      end
      fqmm_cell u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .lo_data (lo_data),
         .hi_data (cell_val[(i + 1) % DEPTH]),
         .value   (cell_val[i])
      );
   end

   // The head cell holds entry step_ff during a scan.
   assign in_range = (CW'(step_ff) < cnt_ff);
   assign cur_pos  = CW'(step_ff) + CW'(1);
   assign match    = (op_ff.opcode == OP_FIND) && in_range &&
                     (head == op_ff.operand_value);
   // A second hit must push the earlier one out before it can be held.
   assign block    = match && hit_ff && !out_free;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      step_in   = step_ff;
      acc_in    = acc_ff;
      hit_in    = hit_ff;
      hitpos_in = hitpos_ff;
      op_in     = op_ff;
      pend_in   = pend_ff;
      out_load  = 1'b0;
      out_data  = '0;
      ctl       = '0;
      imm       = '0;
      imm_valid = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               imm.last  = 1'b1;
               imm_valid = 1'b1;
               if (req_data.opcode == OP_PUSH) begin
                  if (cnt_ff == FullCount) begin
                     imm.status    = ST_FULL;
                     imm.occupancy = to_field(cnt_ff);
                  end else begin
                     ctl.shift     = 1'b1;
                     cnt_in        = cnt_ff + CW'(1);
                     imm.status    = ST_OK;
                     imm.occupancy = to_field(cnt_in);
                  end
               end else if (req_data.opcode > OP_CLEAR) begin
                  imm_valid = 1'b0;
               end else if (cnt_ff == '0) begin
                  imm.status = ST_EMPTY;
               end else if (req_data.opcode == OP_CLEAR) begin
                  cnt_in     = '0;
                  imm.status = ST_OK;
               end else begin
                  imm_valid = 1'b0;
                  state_in  = S_SCAN;
                  step_in   = '0;
                  hit_in    = 1'b0;
                  op_in     = req_data;
               end
               if (imm_valid) begin
                  if (out_free) begin
                     out_load = 1'b1;
                     out_data = imm;
                  end else begin
                     pend_in  = imm;
                     state_in = S_FLUSH;
                  end
               end
            end
         end
         S_SCAN: begin
            if (!block) begin
               ctl.rotate = 1'b1;
               step_in    = step_ff + KW'(1);
               case (op_ff.opcode)
                  OP_POP: begin
                     if (cur_pos == cnt_ff) begin
                        acc_in = head;
                     end
                  end
                  OP_MAX: begin
                     if ((step_ff == '0) || (in_range && (head > acc_ff))) begin
                        acc_in = head;
                     end
                  end
                  OP_MIN: begin
                     if ((step_ff == '0) || (in_range && (head < acc_ff))) begin
                        acc_in = head;
                     end
                  end
                  OP_FIND: begin
                     if (match) begin
                        if (hit_ff) begin
                           out_load              = 1'b1;
                           out_data.status       = ST_OK;
                           out_data.result_value = op_ff.operand_value;
                           out_data.position     = to_field(hitpos_ff);
                           out_data.occupancy    = to_field(cnt_ff);
                           out_data.last         = 1'b0;
                        end
                        hit_in    = 1'b1;
                        hitpos_in = cur_pos;
                     end
                  end
                  default: begin
                  end
               endcase
               if (step_ff == LastStep) begin
                  state_in          = S_FLUSH;
                  pend_in           = '0;
                  pend_in.last      = 1'b1;
                  pend_in.status    = ST_OK;
                  pend_in.occupancy = to_field(cnt_ff);
                  if (op_ff.opcode == OP_FIND) begin
                     if (hit_in) begin
                        pend_in.result_value = op_ff.operand_value;
                        pend_in.position     = to_field(hitpos_in);
                     end else begin
                        pend_in.status = ST_NOT_FOUND;
                     end
                  end else begin
                     pend_in.result_value = acc_in;
                     if (op_ff.opcode == OP_POP) begin
                        cnt_in            = cnt_ff - CW'(1);
                        pend_in.occupancy = to_field(cnt_in);
                     end
                  end
               end
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               out_load = 1'b1;
               out_data = pend_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      acc_ff    <= acc_in;
      hit_ff    <= hit_in;
      hitpos_ff <= hitpos_in;
      op_ff     <= op_in;
      pend_ff   <= pend_in;
      if (out_load) begin
         rsp_ff <= out_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hdl/fqmm_cell.sv */
// ----------------------------------------------------------------------------
// FIFO queue with min/max search: storage cell
// One queue slot that takes its lower neighbor on a push and its upper
// neighbor while the ring rotates.
// ----------------------------------------------------------------------------
module fqmm_cell
   import fqmm_pkg::*;
(
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic signed [31:0] lo_data,
   input  logic signed [31:0] hi_data,
   output logic signed [31:0] value
);

   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.shift) begin
         value_in = lo_data;
      end else if (ctl.rotate) begin
         value_in = hi_data;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

/* hdl/fqmm_checker.sv */
// ----------------------------------------------------------------------------
// FIFO queue with min/max search: port checker
// Checks the result beats seen on the ports of the queue core.
// ----------------------------------------------------------------------------
`include "fifo_queue_with_min_max_search_core_defines.svh"

module fqmm_checker
   import fqmm_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   localparam logic [4:0] FullField = 5'(DEPTH);

   `FQMM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "result beat changed while stalled")
   `FQMM_ASSERT_SAME(a_error_beat, clock, reset, rsp_valid && (rsp_data.status != ST_OK), (rsp_data.result_value == 32'sd0) && (rsp_data.position == 5'd0) && rsp_data.last, "error beat carries data or is not final")
   `FQMM_ASSERT_SAME(a_empty_occ, clock, reset, rsp_valid && (rsp_data.status == ST_EMPTY), rsp_data.occupancy == 5'd0, "empty status with entries held")
   `FQMM_ASSERT_SAME(a_full_occ, clock, reset, rsp_valid && (rsp_data.status == ST_FULL), rsp_data.occupancy == FullField, "full status with free entries")

endmodule

bind fifo_queue_with_min_max_search_core fqmm_checker #(.DEPTH(DEPTH)) u_fqmm_checker (.*);
